/* rtl/assert_macros.svh */
// Assertion macros shared by the checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");

`endif

/* rtl/cre_pkg.sv */
// Package of the column reduction engine: codes, defaults and shared types.
package cre_pkg;

  localparam int DefMaxCols = 1024;
  localparam int DefRowBits = 16;

  localparam logic [2:0] OP_SUM    = 3'd0;
  localparam logic [2:0] OP_MEAN   = 3'd1;
  localparam logic [2:0] OP_MAX    = 3'd2;
  localparam logic [2:0] OP_MIN    = 3'd3;
  localparam logic [2:0] OP_ARGMAX = 3'd4;
  localparam logic [2:0] OP_ARGMIN = 3'd5;

  localparam logic [1:0] EW_8  = 2'd0;
  localparam logic [1:0] EW_16 = 2'd1;
  localparam logic [1:0] EW_32 = 2'd2;
  localparam logic [1:0] EW_64 = 2'd3;

  localparam logic [2:0] REG_OP_MODE     = 3'd0;
  localparam logic [2:0] REG_ELEM_WIDTH  = 3'd1;
  localparam logic [2:0] REG_ELEM_SIGNED = 3'd2;
  localparam logic [2:0] REG_ROW_COUNT   = 3'd3;
  localparam logic [2:0] REG_COL_COUNT   = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPD,
    ST_DIV,
    ST_PUSH
  } cre_state_e;

  typedef struct packed {
    logic accept;
    logic update;
    logic div_step;
    logic push;
  } cre_cmd_t;

  typedef struct packed {
    logic last_row;
    logic is_mean;
    logic div_last;
  } cre_status_t;

endpackage

/* rtl/cre_in_if.sv */
// Stream interfaces of the column reduction engine: input items and result items.
interface cre_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface cre_res_if #(
  parameter int IdxW = 10,
  parameter int RowW = 16
);
  logic            valid;
  logic            ready;
  logic [IdxW-1:0] column;
  logic [63:0]     result_value;
  logic [RowW-1:0] best_row;
  logic            last;
  modport source (output valid, output column, output result_value, output best_row,
                  output last, input ready);
  modport sink (input valid, input column, input result_value, input best_row,
                input last, output ready);
endinterface

/* rtl/cre_ctrl.sv */
// Controller state machine of the column reduction engine.
module cre_ctrl
  import cre_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  cre_status_t status_i,
  output cre_cmd_t    cmd_o
);

  cre_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        cmd_o.update = 1'b1;
        if (!status_i.last_row) begin
          state_d = ST_IDLE;
        end else if (status_i.is_mean) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_PUSH;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // The result moves on only once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/cre_dp.sv */
// Datapath of the column reduction engine: column stores, update logic and mean divider.
module cre_dp
  import cre_pkg::*;
#(
  parameter int MaxCols = DefMaxCols,
  parameter int RowBits = DefRowBits,
  localparam int IdxW   = (MaxCols > 1) ? $clog2(MaxCols) : 1,
  localparam int CntW   = $clog2(MaxCols + 1) + 1
)(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cre_cmd_t        cmd_i,
  output cre_status_t     status_o,
  input  logic            restart_i,
  input  logic [2:0]      op_mode_i,
  input  logic [1:0]      elem_width_i,
  input  logic            elem_signed_i,
  input  logic [15:0]     row_count_i,
  input  logic [10:0]     col_count_i,
  input  logic [63:0]     sample_i,
  output logic [IdxW-1:0] column_o,
  output logic [63:0]     result_value_o,
  output logic [RowBits-1:0] best_row_o,
  output logic            last_o
);

  localparam int RW = RowBits + 1;

  logic [63:0]        acc_mem [MaxCols];
  logic [RowBits-1:0] best_mem [MaxCols];

  logic [IdxW-1:0]    col_pos_q;
  logic [RowBits-1:0] row_pos_q;
  logic [63:0]        x_q, acc_rd_q;
  logic [IdxW-1:0]    c_q;
  logic [RowBits-1:0] r_q, best_rd_q;
  logic [63:0]        res_val_q;
  logic [RowBits-1:0] res_best_q;
  logic               res_last_q;
  logic [63:0]        quo_q;
  logic [RW-1:0]      rem_q;
  logic               neg_q;
  logic [5:0]         cnt_q;
  logic [IdxW-1:0]    out_col_q;
  logic [63:0]        out_val_q;
  logic [RowBits-1:0] out_best_q;
  logic               out_last_q;

  logic [63:0]   mask;
  logic [32:0]   rows_ext, cols_ext, row_lim;
  logic [RW-1:0] rows;
  logic [CntW-1:0] cols;
  logic          last_row, last_col;
  logic [63:0]   kx, ka, new_acc, sum, sext_acc, mag;
  logic [RowBits-1:0] new_best;
  logic          better, is_arg, neg;
  logic [RW:0]   trial;
  logic [63:0]   mean_val;

  function automatic logic [63:0] sext(input logic [63:0] v, input logic [1:0] ew,
                                       input logic sgn);
    logic [63:0] r;
    case (ew)
      EW_8:    r = {{56{sgn & v[7]}}, v[7:0]};
      EW_16:   r = {{48{sgn & v[15]}}, v[15:0]};
      EW_32:   r = {{32{sgn & v[31]}}, v[31:0]};
      default: r = v;
    endcase
    return r;
  endfunction

  always_comb begin
    case (elem_width_i)
      EW_8:    mask = 64'h0000_0000_0000_00FF;
      EW_16:   mask = 64'h0000_0000_0000_FFFF;
      EW_32:   mask = 64'h0000_0000_FFFF_FFFF;
      default: mask = '1;
    endcase
  end

  // Effective counts: zero means one, larger values saturate.
  assign row_lim  = 33'd1 << RowBits;
  assign rows_ext = (row_count_i == 16'd0) ? 33'd1 :
                    (({17'd0, row_count_i} > row_lim) ? row_lim : {17'd0, row_count_i});
  assign cols_ext = (col_count_i == 11'd0) ? 33'd1 :
                    (({22'd0, col_count_i} > 33'(MaxCols)) ? 33'(MaxCols)
                                                           : {22'd0, col_count_i});
  assign rows = rows_ext[RW-1:0];
  assign cols = cols_ext[CntW-1:0];

  assign last_row = ({1'b0, r_q} == rows - RW'(1));
  assign last_col = (CntW'(c_q) == cols - CntW'(1));
  assign is_arg   = (op_mode_i == OP_ARGMAX) || (op_mode_i == OP_ARGMIN);

  always_comb begin
    kx  = sext(x_q, elem_width_i, elem_signed_i) ^ {elem_signed_i, 63'd0};
    ka  = sext(acc_rd_q, elem_width_i, elem_signed_i) ^ {elem_signed_i, 63'd0};
    sum = (acc_rd_q + x_q) & mask;
    case (op_mode_i)
      OP_MAX, OP_ARGMAX: better = kx > ka;
      OP_MIN, OP_ARGMIN: better = kx < ka;
      default:           better = 1'b0;
    endcase
    new_acc  = acc_rd_q;
    new_best = best_rd_q;
    if (r_q == '0) begin
      new_acc  = x_q;
      new_best = '0;
    end else if (op_mode_i == OP_MAX || op_mode_i == OP_ARGMAX ||
                 op_mode_i == OP_MIN || op_mode_i == OP_ARGMIN) begin
      if (better) begin
        new_acc  = x_q;
        new_best = r_q;
      end
    end else begin
      new_acc = sum;
    end
    sext_acc = sext(new_acc, elem_width_i, elem_signed_i);
    neg      = elem_signed_i & sext_acc[63];
    mag      = neg ? (64'd0 - sext_acc) : sext_acc;
    trial    = {rem_q, quo_q[63]};
    mean_val = (neg_q ? (64'd0 - quo_q) : quo_q) & mask;
  end

  assign status_o.last_row = last_row;
  assign status_o.is_mean  = (op_mode_i == OP_MEAN);
  assign status_o.div_last = (cnt_q == 6'd63);

  // Column stores: read on accept, written back during the update cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      acc_rd_q  <= acc_mem[col_pos_q];
      best_rd_q <= best_mem[col_pos_q];
    end
    if (cmd_i.update) begin
      acc_mem[c_q]  <= new_acc;
      best_mem[c_q] <= new_best;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (restart_i) begin
      col_pos_q <= '0;
      row_pos_q <= '0;
    end else if (cmd_i.update) begin
      if (last_col) begin
        col_pos_q <= '0;
        row_pos_q <= last_row ? '0 : r_q + RowBits'(1);
      end else begin
        col_pos_q <= c_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i & mask;
      c_q <= col_pos_q;
      r_q <= row_pos_q;
    end
    if (cmd_i.update) begin
      res_val_q  <= is_arg ? 64'd0 : new_acc;
      res_best_q <= is_arg ? new_best : '0;
      res_last_q <= last_col;
      quo_q      <= mag;
      neg_q      <= neg;
      rem_q      <= '0;
      cnt_q      <= '0;
    end else if (cmd_i.div_step) begin
      // Restoring division, one quotient bit per cycle.
      if (trial >= {1'b0, rows}) begin
        rem_q <= RW'(trial - {1'b0, rows});
        quo_q <= {quo_q[62:0], 1'b1};
      end else begin
        rem_q <= trial[RW-1:0];
        quo_q <= {quo_q[62:0], 1'b0};
      end
      cnt_q <= cnt_q + 6'd1;
    end
    if (cmd_i.push) begin
      out_col_q  <= c_q;
      out_val_q  <= (op_mode_i == OP_MEAN) ? mean_val : res_val_q;
      out_best_q <= res_best_q;
      out_last_q <= res_last_q;
    end
  end

  assign column_o       = out_col_q;
  assign result_value_o = out_val_q;
  assign best_row_o     = out_best_q;
  assign last_o         = out_last_q;

endmodule

/* rtl/column_reduction_engine.sv */
// Each item is read from the column store on accept, then updated and written back; for a
// last-row item a mean result passes through the bit-serial divider, and the result is then
// registered once the output register is free. A new item is taken only when idle again.
// Reset: asynchronous, active low; clears the config and control registers to defaults and the
// column and row positions; column stores are rebuilt from row zero, with no clearing pass.
module column_reduction_engine
  import cre_pkg::*;
#(
  parameter int MaxCols = DefMaxCols,
  parameter int RowBits = DefRowBits
)(
  input  logic         clk_i,
  input  logic         rst_ni,
  cre_in_if.sink       in_i,
  cre_res_if.source    res_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int IdxW = (MaxCols > 1) ? $clog2(MaxCols) : 1;

  // Configuration registers. Any write restarts the matrix at row zero, column zero.
  logic [2:0]  op_mode_q;
  logic [1:0]  elem_width_q;
  logic        elem_signed_q;
  logic [15:0] row_count_q;
  logic [10:0] col_count_q;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  cre_cmd_t    cmd;
  cre_status_t status;
  logic [IdxW-1:0] column;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q     <= OP_SUM;
      elem_width_q  <= EW_8;
      elem_signed_q <= 1'b1;
      row_count_q   <= 16'd1;
      col_count_q   <= 11'd1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_OP_MODE:     op_mode_q     <= pwdata[2:0];
        REG_ELEM_WIDTH:  elem_width_q  <= pwdata[1:0];
        REG_ELEM_SIGNED: elem_signed_q <= pwdata[0];
        REG_ROW_COUNT:   row_count_q   <= pwdata[15:0];
        REG_COL_COUNT:   col_count_q   <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_OP_MODE:     prdata = {29'd0, op_mode_q};
      REG_ELEM_WIDTH:  prdata = {30'd0, elem_width_q};
      REG_ELEM_SIGNED: prdata = {31'd0, elem_signed_q};
      REG_ROW_COUNT:   prdata = {16'd0, row_count_q};
      REG_COL_COUNT:   prdata = {21'd0, col_count_q};
      default:         prdata = 32'd0;
    endcase
  end

  // The controller sequences each item: store read, update, optional divide, output.
  cre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The write restart alone reaches the datapath beside the controller commands; the user
  // must make configuration changes only while the engine is idle; the block does not enforce it.
  cre_dp #(
    .MaxCols (MaxCols),
    .RowBits (RowBits)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .restart_i      (cfg_wr),
    .op_mode_i      (op_mode_q),
    .elem_width_i   (elem_width_q),
    .elem_signed_i  (elem_signed_q),
    .row_count_i    (row_count_q),
    .col_count_i    (col_count_q),
    .sample_i       (in_i.sample),
    .column_o       (column),
    .result_value_o (res_o.result_value),
    .best_row_o     (res_o.best_row),
    .last_o         (res_o.last)
  );

  assign res_o.column = column;

endmodule

/* rtl/cre_checker.sv */
// Port-level checker of the column reduction engine and its bind statement.
`include "assert_macros.svh"

module cre_checker #(
  parameter int IdxW = 10,
  parameter int RowW = 16
)(
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid,
  input logic            in_ready,
  input logic            out_valid,
  input logic            out_ready,
  input logic [IdxW-1:0] column,
  input logic [63:0]     result_value,
  input logic [RowW-1:0] best_row,
  input logic            last,
  input logic            pready
);

  // The engine works on one item at a time, so it is never ready right after an accept.
  `ASSERT_PROP(a_one_item, clk_i, rst_ni, (in_valid && in_ready) |=> !in_ready)
  // No result can appear in the cycle right after an item is accepted.
  `ASSERT_PROP(a_no_early_result, clk_i, rst_ni, (in_valid && in_ready) |=> !$rose(out_valid))
  // A stalled result stays put.
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, (out_valid && !out_ready) |=> (out_valid && $stable(column) && $stable(result_value) && $stable(best_row) && $stable(last)))
  `ASSERT_NEVER(a_pready, clk_i, rst_ni, !pready)

endmodule

bind column_reduction_engine cre_checker #(
  .IdxW ((MaxCols > 1) ? $clog2(MaxCols) : 1),
  .RowW (RowBits)
) u_cre_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid     (in_i.valid),
  .in_ready     (in_i.ready),
  .out_valid    (res_o.valid),
  .out_ready    (res_o.ready),
  .column       (res_o.column),
  .result_value (res_o.result_value),
  .best_row     (res_o.best_row),
  .last         (res_o.last),
  .pready       (pready)
);
